>>> rtl/telnet_option_parser_macros.svh
// Assertion macros for the telnet option parser.
// Depends on nothing; used by the top level, which supplies clk_i and rst_ni.
`ifndef TELNET_OPTION_PARSER_MACROS_SVH
`define TELNET_OPTION_PARSER_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define TNOP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define TNOP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define TNOP_ASSERT(lbl, prop, msg)
`define TNOP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/tnop_pkg.sv
// Shared types and constants of the telnet option parser.
// Depends on nothing; used by the front end, the back end and the top level.
package tnop_pkg;

  // Telnet command bytes
  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;

  // Option codes
  localparam logic [7:0] OPT_ECHO   = 8'd1;
  localparam logic [7:0] OPT_SGA    = 8'd3;
  localparam logic [7:0] OPT_TTYPE  = 8'd24;
  localparam logic [7:0] OPT_NAWS   = 8'd31;
  localparam logic [7:0] OPT_TSPEED = 8'd32;

  // Sizing
  localparam int unsigned SUBNEG_DEPTH = 8;
  localparam int unsigned NAWS_LEN     = 4;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam logic [15:0] COLS_RESET   = 16'd80;
  localparam logic [15:0] LINES_RESET  = 16'd25;

  typedef enum logic [2:0] {
    ST_NORMAL = 3'd0,
    ST_IAC    = 3'd1,
    ST_OPT    = 3'd2,
    ST_SB     = 3'd3,
    ST_OPTDAT = 3'd4,
    ST_SE     = 3'd5
  } state_e;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_REPLY = 2'd1,
    KIND_SIZE  = 2'd2
  } kind_e;

  // Classified work passed from the parser to the back end
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [7:0]  reply_command;
    logic [7:0]  reply_option;
    logic [15:0] naws_cols;
    logic [15:0] naws_lines;
  } token_t;

  // One result as delivered on the output ports
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [7:0]  reply_command;
    logic [7:0]  reply_option;
    logic [15:0] term_cols;
    logic [15:0] term_lines;
  } result_t;

endpackage

>>> rtl/tnop_fifo.sv
// Small register queue with registered storage and count-based flags.
// Depends on nothing; used for the token queue and the result queue.
module tnop_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store the entry being pushed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/tnop_front.sv
// Front end: IAC parser state machine that classifies each received byte.
// Depends on tnop_pkg; feeds tokens into the queue toward the back end.
module tnop_front #(
  parameter int unsigned SUBNEG_DEPTH = tnop_pkg::SUBNEG_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        rx_byte_i,
  output logic              tok_push_o,
  output tnop_pkg::token_t  tok_o
);

  localparam int unsigned CW  = $clog2(SUBNEG_DEPTH + 1);
  localparam int unsigned NIW = $clog2(tnop_pkg::NAWS_LEN);

  tnop_pkg::state_e state_q, state_d;
  logic [7:0]       saved_q, saved_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [7:0]       naws_q [tnop_pkg::NAWS_LEN];
  logic             naws_we;
  logic             peer_offer;
  logic [7:0]       reply_cmd;
  logic             naws_done;

  assign peer_offer = (saved_q == tnop_pkg::B_WILL) || (saved_q == tnop_pkg::B_WONT);
  assign naws_done  = (rx_byte_i == tnop_pkg::B_SE) && (saved_q == tnop_pkg::OPT_NAWS)
                      && (cnt_q == CW'(tnop_pkg::NAWS_LEN));

  // Pick the reply command for an option
  always_comb begin
    if (rx_byte_i == tnop_pkg::OPT_SGA) begin
      reply_cmd = peer_offer ? tnop_pkg::B_DO : tnop_pkg::B_WILL;
    end else if (rx_byte_i inside {tnop_pkg::OPT_TTYPE, tnop_pkg::OPT_NAWS,
                                   tnop_pkg::OPT_TSPEED}) begin
      reply_cmd = tnop_pkg::B_DO;
    end else begin
      reply_cmd = peer_offer ? tnop_pkg::B_DONT : tnop_pkg::B_WONT;
    end
  end

  // Next state and parser registers
  always_comb begin
    state_d = state_q;
    saved_d = saved_q;
    cnt_d   = cnt_q;
    naws_we = 1'b0;
    if (accept_i) begin
      case (state_q)
        tnop_pkg::ST_IAC: begin
          if (rx_byte_i inside {tnop_pkg::B_WILL, tnop_pkg::B_WONT,
                                tnop_pkg::B_DO, tnop_pkg::B_DONT}) begin
            saved_d = rx_byte_i;
            state_d = tnop_pkg::ST_OPT;
          end else if (rx_byte_i == tnop_pkg::B_SB) begin
            state_d = tnop_pkg::ST_SB;
          end else begin
            state_d = tnop_pkg::ST_NORMAL;
          end
        end
        tnop_pkg::ST_OPT: begin
          state_d = tnop_pkg::ST_NORMAL;
        end
        tnop_pkg::ST_SB: begin
          saved_d = rx_byte_i;
          cnt_d   = '0;
          state_d = tnop_pkg::ST_OPTDAT;
        end
        tnop_pkg::ST_OPTDAT: begin
          if (rx_byte_i == tnop_pkg::B_IAC) begin
            state_d = tnop_pkg::ST_SE;
          end else if (cnt_q < CW'(SUBNEG_DEPTH)) begin
            // Only the first bytes matter for a window size; drop the rest
            naws_we = (cnt_q < CW'(tnop_pkg::NAWS_LEN));
            cnt_d   = cnt_q + CW'(1);
          end
        end
        tnop_pkg::ST_SE: begin
          state_d = tnop_pkg::ST_NORMAL;
        end
        default: begin
          state_d = (rx_byte_i == tnop_pkg::B_IAC) ? tnop_pkg::ST_IAC : tnop_pkg::ST_NORMAL;
        end
      endcase
    end
  end

  // Token output for the back end
  always_comb begin
    tok_push_o = 1'b0;
    tok_o      = '0;
    tok_o.kind = tnop_pkg::KIND_DATA;
    if (accept_i) begin
      case (state_q)
        tnop_pkg::ST_IAC: begin
          if (rx_byte_i == tnop_pkg::B_IAC) begin
            tok_push_o      = 1'b1;
            tok_o.data_byte = rx_byte_i;
          end
        end
        tnop_pkg::ST_OPT: begin
          if (rx_byte_i != tnop_pkg::OPT_ECHO) begin
            tok_push_o          = 1'b1;
            tok_o.kind          = tnop_pkg::KIND_REPLY;
            tok_o.reply_command = reply_cmd;
            tok_o.reply_option  = rx_byte_i;
          end
        end
        tnop_pkg::ST_SB, tnop_pkg::ST_OPTDAT: begin
          tok_push_o = 1'b0;
        end
        tnop_pkg::ST_SE: begin
          if (naws_done) begin
            tok_push_o       = 1'b1;
            tok_o.kind       = tnop_pkg::KIND_SIZE;
            tok_o.naws_cols  = {naws_q[0], naws_q[1]};
            tok_o.naws_lines = {naws_q[2], naws_q[3]};
          end
        end
        default: begin
          if (rx_byte_i != tnop_pkg::B_IAC) begin
            tok_push_o      = 1'b1;
            tok_o.data_byte = rx_byte_i;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tnop_pkg::ST_NORMAL;
      saved_q <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      saved_q <= saved_d;
      cnt_q   <= cnt_d;
    end
  end

  // Capture window size bytes
  always_ff @(posedge clk_i) begin
    if (naws_we) begin
      naws_q[cnt_q[NIW-1:0]] <= rx_byte_i;
    end
  end

endmodule

>>> rtl/tnop_back.sv
// Back end: applies window size updates and builds each result.
// Depends on tnop_pkg; drains the token queue into the result queue.
module tnop_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tok_empty_i,
  input  tnop_pkg::token_t  tok_i,
  output logic              tok_pop_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output tnop_pkg::result_t res_o
);

  logic [15:0] cols_q, cols_d, lines_q, lines_d;
  logic        is_size;

  assign tok_pop_o  = !tok_empty_i && !res_full_i;
  assign res_push_o = tok_pop_o;
  assign is_size    = (tok_i.kind == tnop_pkg::KIND_SIZE);

  // Update the terminal size, keeping a register where the peer sent zero
  always_comb begin
    cols_d  = cols_q;
    lines_d = lines_q;
    if (tok_pop_o && is_size) begin
      if (tok_i.naws_cols != '0) begin
        cols_d = tok_i.naws_cols;
      end
      if (tok_i.naws_lines != '0) begin
        lines_d = tok_i.naws_lines;
      end
    end
  end

  // Build the result with the size as of this transaction
  always_comb begin
    res_o.kind          = tok_i.kind;
    res_o.data_byte     = tok_i.data_byte;
    res_o.reply_command = tok_i.reply_command;
    res_o.reply_option  = tok_i.reply_option;
    res_o.term_cols     = cols_d;
    res_o.term_lines    = lines_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q  <= tnop_pkg::COLS_RESET;
      lines_q <= tnop_pkg::LINES_RESET;
    end else begin
      cols_q  <= cols_d;
      lines_q <= lines_d;
    end
  end

endmodule

>>> rtl/telnet_option_parser.sv
// Top level of the telnet receive-side IAC parser.
// Depends on tnop_pkg, tnop_fifo, tnop_front, tnop_back and the assertion macros.
//
// Usage: received bytes enter through a queue-style port (push, full, rx_byte_i);
// a byte is taken at a clock edge with push high and full low. Results leave
// through a queue-style port (empty, pop): the oldest result sits on kind_o and
// the payload ports while empty is low and is taken at an edge with pop high.
// kind 0 carries a data byte (a doubled IAC gives one 255), kind 1 a negotiation
// reply (command and option), kind 2 a window size report; every result also
// shows the current terminal size.
// Throughput: one byte per cycle while full is low, set by the parser state machine
// in the front end and the size update in the back end.
// A byte is registered as a token in the token queue, then as a result.
// Bytes that cause no result (commands, an ECHO option, subnegotiation data)
// leave nothing in the result queue.
// Reset: parser back to normal, both queues empty, size 80 columns by 25 lines.
// Stall: if pop stays low the result queue fills, then the token queue between
// parser and back end fills, and full rises; nothing is lost.
`include "telnet_option_parser_macros.svh"

module telnet_option_parser #(
  parameter int unsigned SUBNEG_DEPTH = tnop_pkg::SUBNEG_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [7:0]  reply_command_o,
  output logic [7:0]  reply_option_o,
  output logic [15:0] term_cols_o,
  output logic [15:0] term_lines_o
);

  localparam int unsigned TOK_W = $bits(tnop_pkg::token_t);
  localparam int unsigned RES_W = $bits(tnop_pkg::result_t);

  logic              accept;
  logic              tok_push, tok_pop, tok_empty, tok_full;
  tnop_pkg::token_t  tok_wdata, tok_rdata;
  logic              res_push;
  logic              res_full;
  tnop_pkg::result_t res_wdata, res_rdata;

  assign accept = push && !tok_full;
  assign full   = tok_full;

  tnop_front #(
    .SUBNEG_DEPTH(SUBNEG_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .tok_push_o (tok_push),
    .tok_o      (tok_wdata)
  );

  tnop_fifo #(
    .WIDTH(TOK_W),
    .DEPTH(tnop_pkg::QUEUE_DEPTH)
  ) u_tok_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tok_push),
    .wdata_i (tok_wdata),
    .pop_i   (tok_pop),
    .rdata_o (tok_rdata),
    .full_o  (tok_full),
    .empty_o (tok_empty)
  );

  tnop_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_empty_i (tok_empty),
    .tok_i       (tok_rdata),
    .tok_pop_o   (tok_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_wdata)
  );

  tnop_fifo #(
    .WIDTH(RES_W),
    .DEPTH(tnop_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_wdata),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .full_o  (res_full),
    .empty_o (empty)
  );

  // Drive the result ports from the head of the result queue
  assign kind_o          = res_rdata.kind;
  assign data_byte_o     = res_rdata.data_byte;
  assign reply_command_o = res_rdata.reply_command;
  assign reply_option_o  = res_rdata.reply_option;
  assign term_cols_o     = res_rdata.term_cols;
  assign term_lines_o    = res_rdata.term_lines;

  // Terminal size never goes to zero: zero fields in a report are ignored
  `TNOP_ASSERT(a_size_nonzero,
    !empty |-> (term_cols_o != 16'd0 && term_lines_o != 16'd0),
    "terminal size reached zero")
  // A reply always carries one of the four negotiation commands
  `TNOP_ASSERT(a_reply_cmd,
    (!empty && kind_o == tnop_pkg::KIND_REPLY) |->
    (reply_command_o == tnop_pkg::B_WILL || reply_command_o == tnop_pkg::B_WONT ||
     reply_command_o == tnop_pkg::B_DO || reply_command_o == tnop_pkg::B_DONT),
    "bad reply command")
  // A token left waiting means the result queue is full
  `TNOP_ASSERT(a_drain, (!tok_empty && !tok_pop) |-> res_full, "back end stalled without cause")
  // Queues hold nothing on the edge after reset is seen
  `TNOP_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (empty && !full), "queues not empty in reset")

endmodule
